FILE: rtl/lph_pkg.sv
// shared types and constants for the linear probing hash table
`default_nettype none
package lph_pkg;

  localparam int KEY_W   = 64;
  localparam int PHONE_W = 50;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  // byte sum of eight key bytes never exceeds 2040
  localparam int SUM_W   = 11;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_FOUND    = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING  = 2'd3;

  typedef struct packed {
    logic               command;
    logic [KEY_W-1:0]   key_bytes;
    logic [PHONE_W-1:0] phone_number;
  } lph_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  slot_index;
    logic [PHONE_W-1:0] found_phone;
    logic [COUNT_W-1:0] probe_count;
  } lph_out_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [PHONE_W-1:0] phone;
  } lph_entry_t;

endpackage
`default_nettype wire

FILE: rtl/linear_probe_hash_table_top.sv
// phone book hash table with linear probing over a slot memory
//
//  port group   dir   payload     moves
//  in_*         in    lph_in_t    one insert or search request
//  out_*        out   lph_out_t   one result per request
//
// a request goes through the byte sum and its remainder by a reciprocal
// multiply, then the probes of 1 to TABLE_SLOTS slots, one slot memory read
// per cycle through its single registered read port, then the result load and
// the output load, before the next one can be taken. after reset a clearing
// pass empties the slot memory while in_stall stays high. one request is worked
// at a time; a finished result waits in the output register under out_stall
// while the next request is already taken.
`default_nettype none
module linear_probe_hash_table_top
  import lph_pkg::*;
#(
  parameter int TABLE_SLOTS = 16,
  parameter int KEY_CHARS   = 8
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire lph_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output lph_out_t     out_data
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 2);
  localparam logic [KEY_W-1:0] KEY_MASK = (KEY_CHARS >= 8) ? {KEY_W{1'b1}} :
      ((KEY_W'(1) << (8 * KEY_CHARS)) - KEY_W'(1));

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [IW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      issued_r, issued_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]      chk_slot_r, chk_slot_nxt;
  logic [CW-1:0]      chk_cnt_r, chk_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               cmd_r, cmd_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PHONE_W-1:0] phone_r, phone_nxt;
  lph_out_t           res_r, res_nxt;
  lph_out_t           out_data_r, out_data_nxt;

  logic               accept;
  logic               hash_done;
  logic [IW-1:0]      home;
  logic               rd_en;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  lph_entry_t         wr_data;
  lph_entry_t         ent;
  logic               hit;
  logic               last;
  logic [IW-1:0]      ptr_inc;

  assign accept  = in_valid && !in_stall;
  assign ptr_inc = (ptr_r == IW'(TABLE_SLOTS - 1)) ? '0 : ptr_r + 1'b1;

  lph_hash #(
    .SLOTS (TABLE_SLOTS),
    .IW    (IW)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .key   (in_data.key_bytes & KEY_MASK),
    .done  (hash_done),
    .home  (home)
  );

  lph_mem #(
    .DEPTH (TABLE_SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (ptr_r),
    .rd_data (ent)
  );

  // a free slot ends an insert, an occupied slot with the same key a search
  always_comb begin
    if (cmd_r == CMD_INSERT) begin
      hit = chk_vld_r && !ent.valid;
    end else begin
      hit = chk_vld_r && ent.valid && (ent.key == key_r);
    end
    last = chk_vld_r && (chk_cnt_r == CW'(TABLE_SLOTS));
  end

  assign rd_en = (state_r == S_PROBE) && (issued_r != CW'(TABLE_SLOTS)) && !hit && !last;

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    issued_nxt    = issued_r;
    chk_vld_nxt   = rd_en;
    chk_slot_nxt  = ptr_r;
    chk_cnt_nxt   = issued_r + 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    phone_nxt     = phone_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r;
    wr_data       = '0;

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        ptr_nxt = ptr_inc;
        if (ptr_r == IW'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_data.command;
          key_nxt   = in_data.key_bytes & KEY_MASK;
          phone_nxt = in_data.phone_number;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          ptr_nxt    = home;
          issued_nxt = '0;
          state_nxt  = S_PROBE;
        end
      end
      S_PROBE: begin
        if (rd_en) begin
          ptr_nxt    = ptr_inc;
          issued_nxt = issued_r + 1'b1;
        end
        if (hit) begin
          res_nxt.slot_index  = SLOT_W'(chk_slot_r);
          res_nxt.probe_count = COUNT_W'(chk_cnt_r);
          if (cmd_r == CMD_INSERT) begin
            res_nxt.status      = ST_INSERTED;
            res_nxt.found_phone = '0;
            wr_en               = 1'b1;
            wr_addr             = chk_slot_r;
            wr_data.valid       = 1'b1;
            wr_data.key         = key_r;
            wr_data.phone       = phone_r;
          end else begin
            res_nxt.status      = ST_FOUND;
            res_nxt.found_phone = ent.phone;
          end
          state_nxt = S_OUT;
        end else if (last) begin
          res_nxt.slot_index  = '0;
          res_nxt.found_phone = '0;
          if (cmd_r == CMD_INSERT) begin
            res_nxt.status      = ST_FULL;
            res_nxt.probe_count = COUNT_W'(TABLE_SLOTS);
          end else begin
            res_nxt.status      = ST_MISSING;
            res_nxt.probe_count = COUNT_W'(TABLE_SLOTS + 1);
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      issued_r    <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      issued_r    <= issued_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_slot_r <= chk_slot_nxt;
    chk_cnt_r  <= chk_cnt_nxt;
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    phone_r    <= phone_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: rtl/lph_mem.sv
// slot store: one write port, one registered read port
`default_nettype none
module lph_mem
  import lph_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire lph_entry_t    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output lph_entry_t         rd_data
);

  lph_entry_t mem [DEPTH];
  lph_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

FILE: rtl/lph_hash.sv
// home slot: byte sum, then its remainder by the table size via a reciprocal multiply
`default_nettype none
module lph_hash
  import lph_pkg::*;
#(
  parameter int SLOTS = 16,
  parameter int IW    = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] key,
  output logic                  done,
  output logic [IW-1:0]         home
);

  // floor(x / SLOTS) equals (x * RECIP) >> SHIFT for every x below 2**SUM_W
  localparam int SHIFT = SUM_W + IW;
  localparam int RW    = SUM_W + 2;
  localparam int PW    = SHIFT + SUM_W;
  localparam logic [63:0] RECIP_VAL =
      ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
  localparam logic [RW-1:0]    RECIP = RECIP_VAL[RW-1:0];
  localparam logic [SUM_W-1:0] DIV   = SUM_W'(SLOTS);

  logic              sum_vld_r;
  logic              quot_vld_r;
  logic              done_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  quot_r;
  logic [IW-1:0]     home_r;
  logic [SUM_W-1:0]  sum;
  logic [PW-1:0]     prod;
  logic [SUM_W-1:0]  back;
  logic [SUM_W-1:0]  rem;

  always_comb begin
    sum = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      sum = sum + SUM_W'(key[8*b +: 8]);
    end
  end

  assign prod = PW'(sum_r) * PW'(RECIP);
  assign back = quot_r * DIV;
  assign rem  = sum_r - back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r  <= 1'b0;
      quot_vld_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      sum_vld_r  <= start;
      quot_vld_r <= sum_vld_r;
      done_r     <= quot_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= sum;
    end
    if (sum_vld_r) begin
      quot_r <= prod[SHIFT +: SUM_W];
    end
    if (quot_vld_r) begin
      home_r <= rem[IW-1:0];
    end
  end

  assign done = done_r;
  assign home = home_r;

endmodule
`default_nettype wire

FILE: rtl/lph_checker.sv
// port-level checks for the hash table, bound to the top level
`default_nettype none
module lph_checker
  import lph_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire lph_out_t out_data
);

  // clearing pass holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request port open right after reset");

  // one request at a time: busy on the cycle after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_phone_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_FOUND |-> out_data.found_phone == '0)
    else $error("phone returned on a result other than found");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_MISSING || out_data.status == ST_FULL)
      |-> out_data.slot_index == '0)
    else $error("slot index set on full or not found");

endmodule

bind linear_probe_hash_table_top lph_checker u_lph_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
